### hdl/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg: shared types and helpers for the ping run-length decoder
// Item layouts, queue entry and status types, sample decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package epr_pkg;

   // sample counter width default
   localparam int DEFAULT_COUNT_BITS = 16;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration reset value
   localparam logic [15:0] SAMPLES_RESET = 16'd1024;

   // chunk field codes
   localparam logic [7:0] ZERO_RUN_MARK = 8'hFF;
   localparam logic [7:0] ZERO_RUN_BIAS = 8'd2;

   // input item
   typedef struct packed {
      logic [31:0] chunk;
      logic        last_chunk;
   } req_type;

   // result item
   typedef struct packed {
      logic [26:0] amplitude;
      logic [15:0] repeat_count;
      logic        ping_end;
   } rsp_type;

   // one queue entry: the results of one input item
   typedef struct packed {
      rsp_type res0;
      rsp_type res1;
      logic    two;
   } epr_entry_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } epr_qstat_type;

   // 12-bit mantissa, 4-bit exponent to linear amplitude
   function automatic logic [26:0] decode_sample(input logic [15:0] word);
      logic [11:0] mant;
      logic [3:0]  expo;
      logic [26:0] value;
      mant = word[11:0];
      expo = word[15:12];
      if (expo == 4'd0) begin
         value = 27'(mant);
      end else begin
         value = 27'({1'b1, mant}) << (expo - 4'd1);
      end
      return value;
   endfunction

endpackage

`default_nettype wire

### hdl/epr_front.sv
// ----------------------------------------------------------------------------
// epr_front: chunk intake and classification
// Holds the configuration register and the sample counter, turns each
// accepted chunk into zero, one or two results and pushes them as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module epr_front import epr_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [15:0]   csr_data,
   input  wire epr_qstat_type q_stat,
   output logic               push,
   output epr_entry_type      push_entry
);

   localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int RW = (COUNT_BITS > 9) ? COUNT_BITS : 9;
   localparam logic [LW-1:0] CountMax = LW'((64'd1 << COUNT_BITS) - 64'd1);

   logic [15:0]           spp_ff;
   logic [COUNT_BITS-1:0] done_ff, done_in;
   logic                  accept;
   logic                  has_result;

   assign req_stall = q_stat.full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & ~q_stat.full;
   assign push      = accept & has_result;

   // classify the chunk and build its results
   always_comb begin
      logic [LW-1:0]         spp_w;
      logic [COUNT_BITS-1:0] limit;
      logic [COUNT_BITS-1:0] left;
      logic [COUNT_BITS-1:0] left1;
      logic [COUNT_BITS-1:0] take;
      logic [RW-1:0]         run_w;
      logic                  has;
      spp_w = LW'(spp_ff);
      limit = (spp_w > CountMax) ? COUNT_BITS'(CountMax) : COUNT_BITS'(spp_w);
      left  = (done_ff < limit) ? (limit - done_ff) : '0;
      run_w = RW'(req_data.chunk[7:0]) + RW'(ZERO_RUN_BIAS);
      take  = (run_w < RW'(left)) ? COUNT_BITS'(run_w) : left;
      has   = (left != '0);
      left1 = left - COUNT_BITS'(has);

      push_entry = '0;
      has_result = 1'b0;
      done_in    = done_ff;

      if (req_data.chunk[15:8] == ZERO_RUN_MARK) begin
         // zero run
         if (req_data.last_chunk) begin
            push_entry.res0 = '{amplitude: '0, repeat_count: 16'(left), ping_end: 1'b1};
            has_result      = 1'b1;
            done_in         = '0;
         end else if (take != '0) begin
            push_entry.res0 = '{amplitude: '0, repeat_count: 16'(take), ping_end: 1'b0};
            has_result      = 1'b1;
            done_in         = done_ff + take;
         end
      end else begin
         // single sample
         if (has) begin
            push_entry.res0 = '{amplitude: decode_sample(req_data.chunk[15:0]),
                                repeat_count: 16'd1,
                                ping_end: req_data.last_chunk & (left1 == '0)};
            has_result      = 1'b1;
            done_in         = done_ff + COUNT_BITS'(1);
         end
         if (req_data.last_chunk) begin
            done_in = '0;
            if (!has) begin
               // end marker only
               push_entry.res0 = '{amplitude: '0, repeat_count: '0, ping_end: 1'b1};
               has_result      = 1'b1;
            end else if (left1 != '0) begin
               // padding after the sample
               push_entry.res1 = '{amplitude: '0, repeat_count: 16'(left1),
                                   ping_end: 1'b1};
               push_entry.two  = 1'b1;
            end
         end
      end
   end

   // configuration and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff  <= SAMPLES_RESET;
         done_ff <= '0;
      end else begin
         if (csr_valid) begin
            spp_ff <= csr_data;
         end
         if (accept) begin
            done_ff <= done_in;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/epr_queue.sv
// ----------------------------------------------------------------------------
// epr_queue: short entry queue between front and back
// Flip-flop storage, one write and one read pointer, fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module epr_queue import epr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire epr_entry_type push_entry,
   input  wire logic          pop,
   output epr_entry_type      head,
   output epr_qstat_type      q_stat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   epr_entry_type store_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head         = store_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

### hdl/epr_back.sv
// ----------------------------------------------------------------------------
// epr_back: result sequencer
// Takes queue entries and sends their one or two results through the
// output register, one result per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module epr_back import epr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire epr_entry_type head,
   input  wire epr_qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data
);

   logic    valid_ff;
   logic    sel_ff;
   rsp_type data_ff;
   logic    load;
   logic    take;

   assign load      = ~valid_ff | ~rsp_stall;
   assign take      = load & ~q_stat.empty;
   assign pop       = take & (sel_ff | ~head.two);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // output payload
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= sel_ff ? head.res1 : head.res0;
      end
   end

   // output valid and result select
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            sel_ff   <= ~sel_ff & head.two;
         end else if (load) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/echo_ping_rle_float_decoder.sv
// ----------------------------------------------------------------------------
// echo_ping_rle_float_decoder: echo-sounder ping decoder, zero-run expansion
// Decodes sample chunks and zero runs into run-coded results per ping.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| req_type (chunk, last_chunk)
//   rsp     | out       | rsp_valid/rsp_stall| rsp_type (amplitude, repeat_count, ping_end)
//   csr     | in        | csr_valid/csr_ready| samples_per_ping, 16 bits
//
// One chunk is accepted per cycle while the queue is not full; results leave
// one per cycle while rsp_stall is low, through a single output register, so
// a chunk giving two results holds that register for both. A four-entry queue
// sits between intake and output; a result passes the queue, then that register.
// Synchronous reset clears the counter, queue and output valid and sets
// samples_per_ping to 1024. Output stalls fill the queue; req_stall is high
// while all four entries are held.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_ping_rle_float_decoder import epr_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   epr_qstat_type q_stat;
   epr_entry_type push_entry;
   epr_entry_type head;
   logic          push;
   logic          pop;

   epr_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_entry(push_entry)
   );

   epr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   epr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### dv/epr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_checker: result predictor and scoreboard for the ping decoder
// Watches the csr, req and rsp channels, expands each accepted chunk into
// its run-coded results and compares them in order with what the block emits.
// ----------------------------------------------------------------------------

module epr_checker import epr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending
);

   // shadow of the block's register and sample counter
   logic [15:0] ping_limit = SAMPLES_RESET;
   logic [15:0] samples_done = '0;

   // results still owed by the block, oldest first
   rsp_type owed_results[$];
   int      failures = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // 12-bit mantissa with 4-bit exponent to linear amplitude
   function automatic logic [26:0] sample_amplitude(input logic [15:0] word);
      logic [26:0] mantissa;
      logic [3:0]  exponent;
      mantissa = 27'(word[11:0]);
      exponent = word[15:12];
      if (exponent == 4'd0) begin
         return mantissa;
      end
      return (mantissa + 27'h1000) << (exponent - 4'd1);
   endfunction

   function automatic void owe_result(input logic [26:0] amplitude,
                                      input int unsigned count, input logic closes);
      rsp_type res;
      res.amplitude = amplitude;
      res.repeat_count = count[15:0];
      res.ping_end = closes;
      owed_results.push_back(res);
   endfunction

   // expand one chunk into the results it causes and advance the counter
   task automatic expand_chunk(input req_type item);
      int unsigned left;
      int unsigned run;
      int unsigned take;
      int          produced;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      left = (samples_done < ping_limit) ? ping_limit - samples_done : 0;
      first_byte = item.chunk[7:0];
      second_byte = item.chunk[15:8];
      produced = 0;
      if (second_byte == ZERO_RUN_MARK) begin
         if (item.last_chunk) begin
            // zero run merges with the end padding
            owe_result('0, left, 1'b1);
            samples_done = '0;
         end else begin
            run = first_byte + ZERO_RUN_BIAS;
            take = (run < left) ? run : left;
            if (take > 0) begin
               owe_result('0, take, 1'b0);
               samples_done = samples_done + take[15:0];
            end
         end
      end else begin
         // single sample, dropped once the ping is full
         if (left > 0) begin
            left = left - 1;
            owe_result(sample_amplitude(item.chunk[15:0]), 1,
                       item.last_chunk && left == 0);
            samples_done = samples_done + 16'd1;
            produced = 1;
         end
         if (item.last_chunk) begin
            // padding, or a bare end marker when nothing is left
            if (left > 0 || produced == 0) begin
               owe_result('0, left, 1'b1);
            end
            samples_done = '0;
         end
      end
   endtask

   // track csr writes, compare one emitted item with the oldest owed result and expand accepted chunks
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ping_limit = SAMPLES_RESET;
         samples_done = '0;
         owed_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ping_limit = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b",
                        $time, rsp_data.amplitude, rsp_data.repeat_count,
                        rsp_data.ping_end);
               failures++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.amplitude !== want.amplitude) begin
                  $display("%0t: amplitude mismatch, expected %0d, actual %0d",
                           $time, want.amplitude, rsp_data.amplitude);
                  failures++;
               end
               if (rsp_data.repeat_count !== want.repeat_count) begin
                  $display("%0t: repeat_count mismatch, expected %0d, actual %0d",
                           $time, want.repeat_count, rsp_data.repeat_count);
                  failures++;
               end
               if (rsp_data.ping_end !== want.ping_end) begin
                  $display("%0t: ping_end mismatch, expected %0b, actual %0b",
                           $time, want.ping_end, rsp_data.ping_end);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expand_chunk(req_data);
         end
      end
      fail_count <= failures;
      pending <= owed_results.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for echo_ping_rle_float_decoder
// Directed chunks for each decode and padding case, then random pings over
// several ping lengths with shifting idle and stall pressure on both sides.
// ----------------------------------------------------------------------------

module testbench;
   import epr_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_SETTING = 140;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          cycles = 0;

   echo_ping_rle_float_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   epr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // offer one chunk, with an optional gap first, and wait until taken
   task automatic send_chunk(input logic [31:0] chunk, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.chunk <= chunk;
      req_data.last_chunk <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // let the block drain, then write samples_per_ping
   task automatic set_ping_length(input logic [15:0] count);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // one well-formed ping of random samples and zero runs, some raw noise
   task automatic send_ping(input int chunks, inout int sent);
      logic [31:0] chunk;
      int          pick;
      for (int i = 0; i < chunks; i++) begin
         chunk = $urandom;
         pick = $urandom_range(99);
         if (pick < 62) begin
            if (chunk[15:8] == ZERO_RUN_MARK) begin
               chunk[15:8] = 8'($urandom_range(0, 254));
            end
            send_chunk(chunk, i == chunks - 1);
         end else if (pick < 94) begin
            chunk[15:8] = ZERO_RUN_MARK;
            if ($urandom_range(1)) begin
               chunk[7:0] = 8'($urandom_range(0, 12));
            end
            send_chunk(chunk, i == chunks - 1);
         end else begin
            send_chunk(chunk, 1'($urandom_range(1)));
         end
         sent++;
      end
   endtask

   initial begin
      int          sent;
      logic [15:0] count;
      send_idle_pct <= 23;
      recv_stall_pct <= 78;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // decode extremes and padding at the reset ping length
      send_chunk(32'h0000_0000, 1'b0);
      send_chunk(32'hFFFF_FEFF, 1'b0);
      send_chunk(32'h0000_1000, 1'b0);
      send_chunk(32'h1234_0FFF, 1'b0);
      send_chunk(32'h0000_FF00, 1'b0);
      send_chunk(32'hABCD_FFFF, 1'b0);
      send_chunk(32'h0000_8123, 1'b1);
      send_chunk(32'h0000_FF05, 1'b1);
      send_chunk(32'h0000_0001, 1'b1);

      // short ping: sample fills it on the last chunk
      set_ping_length(16'd3);
      send_chunk(32'h0000_0042, 1'b0);
      send_chunk(32'h0000_0043, 1'b0);
      send_chunk(32'h0000_7044, 1'b1);
      // ping full: dropped sample, then bare end marker
      send_chunk(32'h0000_0001, 1'b0);
      send_chunk(32'h0000_0001, 1'b0);
      send_chunk(32'h0000_0001, 1'b0);
      send_chunk(32'h0000_0002, 1'b0);
      send_chunk(32'h0000_0003, 1'b1);
      // zero run cut short, cut to nothing, last run with nothing left
      send_chunk(32'h0000_FF10, 1'b0);
      send_chunk(32'h0000_FF00, 1'b0);
      send_chunk(32'h0000_FF00, 1'b1);

      // zero length: everything drops, last chunk gives the marker
      set_ping_length(16'd0);
      send_chunk(32'h0000_0005, 1'b0);
      send_chunk(32'h0000_FF01, 1'b0);
      send_chunk(32'h0000_0007, 1'b1);

      // random pings: three pressure phases, three ping lengths each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 23;
               recv_stall_pct <= 78;
            end
            1: begin
               send_idle_pct <= 78;
               recv_stall_pct <= 23;
            end
            default: begin
               send_idle_pct <= 0;
               recv_stall_pct <= 0;
            end
         endcase
         for (int setting = 0; setting < 3; setting++) begin
            case (phase * 3 + setting)
               0: count = 16'd1;
               1: count = 16'($urandom_range(2, 12));
               2: count = 16'hFFFF;
               3: count = 16'($urandom_range(13, 60));
               4: count = 16'($urandom_range(1, 65535));
               5: count = 16'($urandom_range(2, 8));
               6: count = SAMPLES_RESET;
               7: count = 16'($urandom_range(1, 300));
               default: count = 16'($urandom_range(2, 20));
            endcase
            set_ping_length(count);
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
               send_ping($urandom_range(1, 24), sent);
            end
         end
      end

      // drain and give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### echo_ping_rle_float_decoder.f
hdl/epr_pkg.sv
hdl/epr_front.sv
hdl/epr_queue.sv
hdl/epr_back.sv
hdl/echo_ping_rle_float_decoder.sv
dv/epr_checker.sv
dv/testbench.sv
